FILE: hw/rtl/tsom_pkg.sv
// Shared types and constants of the tree SOM training block.
package tsom_pkg;

    localparam int MaxNodes   = 1024;
    localparam int Features   = 8;
    localparam int NodeW      = 10;
    localparam int FeatW      = 3;
    localparam int AddrW      = NodeW + FeatW;
    localparam int DistW      = 36;

    localparam logic [15:0] RateDecay    = 16'd58982;
    localparam logic [15:0] SiblingScale = 16'd13107;

    localparam logic [1:0] OpWrite  = 2'd0;
    localparam logic [1:0] OpRead   = 2'd1;
    localparam logic [1:0] OpSample = 2'd2;

    localparam logic       KindMatch = 1'b0;
    localparam logic       KindRead  = 1'b1;

    localparam logic       RegChildren = 1'b0;
    localparam logic       RegHeight   = 1'b1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [NodeW-1:0]   node_index;
        logic [FeatW-1:0]   feature_index;
        logic signed [15:0] value;
        logic               last_feature;
        logic [15:0]        learning_rate;
        logic               neighbourhood_on;
    } t_in_req;

    typedef struct packed {
        logic               result_kind;
        logic [NodeW-1:0]   best_node;
        logic signed [15:0] read_value;
        logic               size_error;
    } t_out_req;

endpackage

FILE: hw/rtl/tree_som_train_step.sv
// Tree-structured SOM training step: weight store access, tree descent and update walk.
// A weight write and a sample feature without the last flag leave the block idle, so the
// next request may follow at once. A read holds the block through S_RDWAIT, where the
// weight is read, and S_RDOUT, where its result is registered. On the last feature the
// block checks the tree size one level at a time, then decides: with k below 2 or more
// than MaxNodes nodes it returns a size error, else it descends from the root: for each
// of the h levels and each of the k children it streams the 8 features of the child
// through one shared subtract/square/accumulate unit, one feature at a time from the
// single-port weight memory (read, wait, accumulate), then compares. The update walk
// moves the leaf and, with the neighbourhood flag, each ancestor and the siblings of the
// leaf and of each ancestor below the root, again one feature at a time (read, wait,
// multiply, write back), then picks the next node; at each level the rate is scaled by
// the decay and then by the sibling factor, and the node itself is skipped among its
// siblings. The default tree after reset has k=4 and h=3. The block is not ready while
// an item is in work; a finished result sits in an output register, and the next request
// is taken only once that result is taken, at the earliest in the same cycle. No clearing
// pass is needed after reset.
module tree_som_train_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tsom_pkg::t_in_req    i_req,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tsom_pkg::t_out_req   o_req,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDWAIT = 4'd1;
    localparam logic [3:0] S_RDOUT  = 4'd2;
    localparam logic [3:0] S_SIZE   = 4'd3;
    localparam logic [3:0] S_DRD    = 4'd4;
    localparam logic [3:0] S_DACC   = 4'd5;
    localparam logic [3:0] S_DCMP   = 4'd6;
    localparam logic [3:0] S_URD    = 4'd7;
    localparam logic [3:0] S_UMUL   = 4'd8;
    localparam logic [3:0] S_UWR    = 4'd9;
    localparam logic [3:0] S_NEXT   = 4'd10;
    localparam logic [3:0] S_SCALE  = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;
    localparam logic [3:0] S_DWAIT  = 4'd13;
    localparam logic [3:0] S_UWAIT  = 4'd14;

    // configuration
    logic [3:0] r_k, r_h;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 4'd4;
            r_h <= 4'd3;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == tsom_pkg::RegChildren) r_k <= pwdata[3:0];
            else                                   r_h <= pwdata[3:0];
        end
    end
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == tsom_pkg::RegChildren) prdata[3:0] = r_k;
        else                                   prdata[3:0] = r_h;
    end

    // storage: single-port weight memory, small sample buffer read at the feature counter
    logic signed [15:0] r_mem [tsom_pkg::MaxNodes*tsom_pkg::Features];
    logic signed [15:0] r_smp [tsom_pkg::Features];
    logic                           mem_we;
    logic [tsom_pkg::AddrW-1:0]     mem_addr;
    logic signed [15:0]             mem_wd;
    logic signed [15:0]             r_rd;
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wd;
        r_rd <= r_mem[mem_addr];
    end

    // sequencer state
    logic [3:0]                 r_st;
    tsom_pkg::t_in_req          r_in;
    logic [12:0]                r_cur;   // node being walked; wide enough for k*n+k
    logic [12:0]                r_best;
    logic [12:0]                r_first; // first child of the level or sibling group
    logic [3:0]                 r_c;     // child counter
    logic [3:0]                 r_lvl;   // level in the descent, depth of r_cur in the walk
    logic [2:0]                 r_f;
    logic [tsom_pkg::DistW-1:0] r_acc, r_bd;
    logic [12:0]                r_pick;
    logic [15:0]                r_rate, r_srate;
    logic                       r_sib;   // walking siblings of r_cur
    logic [12:0]                r_total, r_lvlsz;
    logic signed [16:0]         r_diff;
    logic signed [33:0]         r_prod;
    logic                       r_ov;
    logic                       r_oval;
    tsom_pkg::t_out_req         r_out;
    logic [12:0]                r_path [10]; // node picked at each depth, root at depth 0

    assign o_ready = (r_st == S_IDLE) && !(r_oval && !i_ready);
    assign o_valid = r_oval;
    assign o_req   = r_out;

    logic signed [16:0] diff;
    logic [33:0]        sq;
    logic signed [33:0] step;
    logic [31:0]        scaled;
    logic [12:0]        tgt;
    logic [16:0]        kmul;
    assign diff   = 17'(r_rd) - 17'(r_smp[r_f]);
    assign sq     = 34'(r_diff * r_diff);
    assign step   = r_prod >>> 16;
    assign scaled = r_rate * (r_sib ? tsom_pkg::SiblingScale : tsom_pkg::RateDecay);
    assign tgt    = r_first + 13'(r_c);
    assign kmul   = r_lvlsz * r_k;

    always_comb begin
        mem_we   = 1'b0;
        mem_wd   = r_rd - step[15:0];
        mem_addr = {tgt[tsom_pkg::NodeW-1:0], r_f};
        case (r_st)
            S_IDLE: begin
                mem_addr = {i_req.node_index, i_req.feature_index};
                mem_wd   = i_req.value;
                mem_we   = i_valid && o_ready && i_req.operation == tsom_pkg::OpWrite;
            end
            S_RDWAIT: mem_addr = {r_in.node_index, r_in.feature_index};
            S_UWR:   mem_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_oval <= 1'b0;
        end else begin
            if (r_oval && i_ready) r_oval <= 1'b0;
            case (r_st)
                S_IDLE: if (i_valid && o_ready) begin
                    r_in <= i_req;
                    case (i_req.operation)
                        tsom_pkg::OpRead: r_st <= S_RDWAIT;
                        tsom_pkg::OpSample: begin
                            r_smp[i_req.feature_index] <= i_req.value;
                            if (i_req.last_feature) begin
                                r_st <= S_SIZE;
                                r_total <= 13'd1; r_lvlsz <= 13'd1; r_lvl <= 4'd0;
                                r_ov <= (r_k < 4'd2);
                            end
                        end
                        default: ;
                    endcase
                end
                S_RDWAIT: r_st <= S_RDOUT;
                S_RDOUT: begin
                    r_out <= '{tsom_pkg::KindRead, '0, r_rd, 1'b0};
                    r_oval <= 1'b1;
                    r_st <= S_IDLE;
                end
                S_SIZE: begin
                    if (r_ov || r_lvl == r_h) begin
                        if (r_ov) begin
                            r_out <= '{tsom_pkg::KindMatch, '0, '0, 1'b1};
                            r_oval <= 1'b1;
                            r_st <= S_IDLE;
                        end else begin
                            r_best <= '0; r_cur <= '0; r_lvl <= 4'd0;
                            r_c <= 4'd0; r_f <= '0; r_acc <= '0; r_sib <= 1'b0;
                            r_rate <= r_in.learning_rate;
                            r_path[0] <= '0;
                            if (r_h == 4'd0) begin
                                // root only: it is the best match, move it straight away
                                r_first <= '0;
                                r_st <= S_URD;
                            end else begin
                                r_first <= 13'd1;
                                r_st <= S_DRD;
                            end
                        end
                    end else begin
                        if (kmul > 17'(tsom_pkg::MaxNodes) ||
                            18'(r_total) + 18'(kmul) > 18'(tsom_pkg::MaxNodes))
                            r_ov <= 1'b1;
                        r_lvlsz <= kmul[12:0];
                        r_total <= r_total + kmul[12:0];
                        r_lvl <= r_lvl + 4'd1;
                    end
                end
                // descent: tgt = r_first + r_c walks the children of the level
                S_DRD: r_st <= S_DWAIT;
                S_DWAIT: begin r_diff <= diff; r_st <= S_DACC; end
                S_DACC: begin
                    r_acc <= r_acc + tsom_pkg::DistW'(sq);
                    if (r_f == 3'(tsom_pkg::Features - 1)) r_st <= S_DCMP;
                    else begin r_f <= r_f + 3'd1; r_st <= S_DRD; end
                end
                S_DCMP: begin
                    logic [12:0] pk;
                    pk = (r_c == 4'd0 || r_acc < r_bd) ? r_first + 13'(r_c) : r_pick;
                    if (r_c == 4'd0 || r_acc < r_bd) r_bd <= r_acc;
                    r_pick <= pk;
                    r_f <= '0; r_acc <= '0;
                    if (r_c + 4'd1 < r_k) begin
                        r_c <= r_c + 4'd1; r_st <= S_DRD;
                    end else begin
                        r_path[r_lvl + 4'd1] <= pk;
                        r_lvl <= r_lvl + 4'd1;
                        r_c <= 4'd0;
                        if (r_lvl + 4'd1 < r_h) begin
                            r_first <= 13'(pk * r_k) + 13'd1;
                            r_st <= S_DRD;
                        end else begin
                            r_best <= pk; r_cur <= pk; r_first <= pk;
                            r_sib <= 1'b0; r_rate <= r_in.learning_rate;
                            r_st <= S_URD;
                        end
                    end
                end
                // update walk: with r_sib=0, tgt = r_first (= r_cur), r_c = 0
                S_URD: r_st <= S_UWAIT;
                S_UWAIT: begin r_diff <= diff; r_st <= S_UMUL; end
                S_UMUL: begin
                    r_prod <= r_diff * $signed({1'b0, r_sib ? r_srate : r_rate});
                    r_st <= S_UWR;
                end
                S_UWR: begin
                    if (r_f == 3'(tsom_pkg::Features - 1)) begin
                        r_f <= '0; r_st <= S_NEXT;
                    end else begin
                        r_f <= r_f + 3'd1; r_st <= S_URD;
                    end
                end
                S_NEXT: begin
                    if (!r_sib) begin
                        if (!r_in.neighbourhood_on || r_cur == 13'd0) r_st <= S_DONE;
                        else r_st <= S_SCALE;
                    end else begin
                        logic [12:0] s;
                        s = r_first + 13'(r_c) + 13'd1;
                        if (r_c + 4'd1 < r_k) begin
                            r_c <= r_c + 4'd1;
                            r_st <= (s == r_cur) ? S_NEXT : S_URD;
                        end else begin
                            // siblings done: move up to the parent
                            r_cur <= r_path[r_lvl - 4'd1];
                            r_first <= r_path[r_lvl - 4'd1];
                            r_lvl <= r_lvl - 4'd1;
                            r_c <= 4'd0; r_sib <= 1'b0;
                            r_st <= S_URD;
                        end
                    end
                end
                S_SCALE: begin
                    // two passes: decay into r_rate, then sibling rate from it
                    if (!r_sib) begin
                        r_rate <= scaled[31:16];
                        r_sib <= 1'b1;
                        r_first <= 13'(r_path[r_lvl - 4'd1] * r_k) + 13'd1;
                        r_c <= 4'd0;
                    end else begin
                        r_srate <= scaled[31:16];
                        r_st <= (r_first == r_cur) ? S_NEXT : S_URD;
                    end
                end
                S_DONE: begin
                    r_out <= '{tsom_pkg::KindMatch, r_best[tsom_pkg::NodeW-1:0], '0, 1'b0};
                    r_oval <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_st == S_IDLE) else $error("ready outside idle");
    a_read_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_RDOUT) |=> o_valid && o_req.result_kind == tsom_pkg::KindRead)
        else $error("read result missing");
    a_err_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_req.size_error |-> o_req.best_node == '0) else $error("error node");
    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_st == S_UWR || r_st == S_IDLE) else $error("stray write");
`endif

endmodule
